// ----- sv/mexp_pkg.sv -----
// package: shared widths, controller states and command/status structs for modexp
package mexp_pkg;

    localparam int MOD_WIDTH_DEF = 62;
    localparam int BASE_W        = 62;
    localparam int EXP_W         = 63;
    localparam int RES_W         = 62;
    localparam int CFG_W         = 62;
    localparam int IN_TDATA_W    = 128;
    localparam int OUT_TDATA_W   = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC_START,
        S_ACC_STEP,
        S_SQ_START,
        S_SQ_STEP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture accepted word
        logic mul_start;   // clear product, load operands
        logic mul_sel_sq;  // 1: base*base, 0: acc*base
        logic mul_step;    // one shift-add step
        logic commit_acc;  // acc <= product
        logic commit_sq;   // base <= product, exponent >>= 1
        logic emit;        // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_bad;        // incoming base not below modulus
        logic in_exp_zero;   // incoming exponent is zero
        logic in_exp_lsb;    // incoming exponent bit 0
        logic mb_zero;       // no multiplier bits left
        logic exp_rest_zero; // exponent bits above bit 0 all zero
        logic exp_bit1;      // exponent bit 1
        logic out_busy;      // output register holds a word not taken this cycle
    } t_stat;

endpackage

// ----- sv/modular_exponentiation_top.sv -----
// top level: modular exponentiation by right-to-left square-and-multiply
// sequence: a flagged base or zero exponent goes straight to the result; otherwise each set
//   exponent bit gets a multiply and each bit below the highest set bit gets a square
// throughput: one word at a time, each product set by
//   the single shift-add multiplier stepping one multiplier bit per cycle
// reset: synchronous active low; modulus returns to 1, controller idles, output empties
module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // modulus register write, low MOD_WIDTH bits kept
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [61:0] base, [124:62] exponent, rest zero
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [61:0] residue, rest zero
    output logic                   m_axis_tuser    // [0] bad_operand
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: ready only while idle, one word in flight
    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // operands, multiplier and output register; the output register lets
    // the next word enter while a result is still waiting
    mexp_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_bad   (m_axis_tuser)
    );

endmodule

// ----- sv/mexp_datapath.sv -----
// datapath: modulus register, operand registers, shift-add modular multiplier, output register
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_out_ready,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic                   o_out_bad
);

    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_base;
    logic [EXP_W-1:0]     r_exp;
    logic [MOD_WIDTH-1:0] r_acc;
    logic                 r_bad;
    logic [MOD_WIDTH-1:0] r_pa;
    logic [MOD_WIDTH-1:0] r_dbl;
    logic [MOD_WIDTH-1:0] r_mb;
    logic [MOD_WIDTH-1:0] r_res;
    logic                 r_res_bad;
    logic                 r_out_valid;

    logic [BASE_W-1:0]    in_base;
    logic [EXP_W-1:0]     in_exp;
    logic                 in_bad;
    logic [MOD_WIDTH:0]   mod_ext;
    logic [MOD_WIDTH:0]   pa_sum;
    logic [MOD_WIDTH:0]   dbl_sum;
    logic [MOD_WIDTH-1:0] n_pa;
    logic [MOD_WIDTH-1:0] n_dbl;

    assign in_base = i_in_data[BASE_W-1:0];
    assign in_exp  = i_in_data[BASE_W +: EXP_W];
    assign in_bad  = in_base >= BASE_W'(r_mod);
    assign mod_ext = {1'b0, r_mod};

    // one doubling step with conditional subtract on both running values
    always_comb begin
        pa_sum  = {1'b0, r_pa} + {1'b0, r_dbl};
        dbl_sum = {1'b0, r_dbl} + {1'b0, r_dbl};
        if (!r_mb[0]) begin
            n_pa = r_pa;
        end else if (pa_sum >= mod_ext) begin
            n_pa = MOD_WIDTH'(pa_sum - mod_ext);
        end else begin
            n_pa = pa_sum[MOD_WIDTH-1:0];
        end
        if (dbl_sum >= mod_ext) begin
            n_dbl = MOD_WIDTH'(dbl_sum - mod_ext);
        end else begin
            n_dbl = dbl_sum[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= in_base[MOD_WIDTH-1:0];
            r_exp  <= in_exp;
            r_acc  <= in_bad ? '0 : MOD_WIDTH'(1);
            r_bad  <= in_bad;
        end
        if (i_cmd.mul_start) begin
            r_pa  <= '0;
            r_dbl <= i_cmd.mul_sel_sq ? r_base : r_acc;
            r_mb  <= r_base;
        end else if (i_cmd.mul_step) begin
            r_pa  <= n_pa;
            r_dbl <= n_dbl;
            r_mb  <= r_mb >> 1;
        end
        if (i_cmd.commit_acc) begin
            r_acc <= r_pa;
        end
        if (i_cmd.commit_sq) begin
            r_base <= r_pa;
            r_exp  <= r_exp >> 1;
        end
        if (i_cmd.emit) begin
            r_res     <= r_acc;
            r_res_bad <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.in_bad        = in_bad;
    assign o_stat.in_exp_zero   = in_exp == '0;
    assign o_stat.in_exp_lsb    = in_exp[0];
    assign o_stat.mb_zero       = r_mb == '0;
    assign o_stat.exp_rest_zero = r_exp[EXP_W-1:1] == '0;
    assign o_stat.exp_bit1      = r_exp[1];
    assign o_stat.out_busy      = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_TDATA_W'(r_res);
    assign o_out_bad   = r_res_bad;

    // products always end reduced below the modulus
    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit_acc || i_cmd.commit_sq) |-> (r_pa < r_mod))
        else $error("modular product not reduced");

    // a loaded output word is presented the next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("output word lost after emit");

endmodule

// ----- sv/mexp_ctrl.sv -----
// controller: sequences square-and-multiply over exponent bits and shift-add steps
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_bad || i_stat.in_exp_zero) begin
                        n_state = S_DONE;
                    end else if (i_stat.in_exp_lsb) begin
                        n_state = S_ACC_START;
                    end else begin
                        n_state = S_SQ_START;
                    end
                end
            end
            S_ACC_START: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_ACC_STEP;
            end
            S_ACC_STEP: begin
                if (i_stat.mb_zero) begin
                    o_cmd.commit_acc = 1'b1;
                    // last set bit done, the remaining squares do not matter
                    n_state = i_stat.exp_rest_zero ? S_DONE : S_SQ_START;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_SQ_START: begin
                o_cmd.mul_start  = 1'b1;
                o_cmd.mul_sel_sq = 1'b1;
                n_state          = S_SQ_STEP;
            end
            S_SQ_STEP: begin
                if (i_stat.mb_zero) begin
                    o_cmd.commit_sq = 1'b1;
                    if (i_stat.exp_rest_zero) begin
                        n_state = S_DONE;
                    end else if (i_stat.exp_bit1) begin
                        n_state = S_ACC_START;
                    end else begin
                        n_state = S_SQ_START;
                    end
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // never overwrite a word still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_stat.out_busy)
        else $error("output overwritten while stalled");

    // every accepted word leaves idle
    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != S_IDLE))
        else $error("accepted word dropped");

    // commit only when the multiplier has run out of bits
    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit_acc || o_cmd.commit_sq) |-> (i_stat.mb_zero && !o_cmd.mul_step))
        else $error("commit before product finished");

endmodule
